// ===== rtl/amp_pkg.sv =====
package amp_pkg;

	// run length limit and field widths
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int BLK_W          = 128;
	localparam int HALF_W         = 64;
	localparam int NBLK_W         = 7;
	localparam int IDX_W          = 6;
	localparam int ROUND_W        = 4;
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(10);

	// fixed chaining IV for the generator mode
	localparam logic [BLK_W-1:0] FIXED_IV = 128'h2b7e151628aed2a6abf7158809cf4f3c;

	// first round constant and field reduction term
	localparam logic [7:0] RC_INIT = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

endpackage

// ===== rtl/amp_req_if.sv =====
interface amp_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic [63:0] msg_hi;
	logic [63:0] msg_lo;
	logic [6:0]  n_blocks;

	modport source(output valid, func, key_hi, key_lo, msg_hi, msg_lo, n_blocks,
		input ready);
	modport sink(input valid, func, key_hi, key_lo, msg_hi, msg_lo, n_blocks,
		output ready);
endinterface

// ===== rtl/amp_rsp_if.sv =====
interface amp_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_hi;
	logic [63:0] block_lo;
	logic [5:0]  block_index;
	logic        last;

	modport source(output valid, block_hi, block_lo, block_index, last, input ready);
	modport sink(input valid, block_hi, block_lo, block_index, last, output ready);
endinterface

// ===== rtl/amp_round.sv =====
// One AES-128 round together with the matching key schedule step.
module amp_round (
	input  logic [amp_pkg::BLK_W-1:0] st,
	input  logic [amp_pkg::BLK_W-1:0] rk,
	input  logic [7:0]                rc,
	input  logic                      mix,
	output logic [amp_pkg::BLK_W-1:0] st_nxt,
	output logic [amp_pkg::BLK_W-1:0] rk_nxt
);

	logic [7:0] sb [0:15];
	logic [7:0] ob [0:15];
	logic [7:0] kb [0:15];
	logic [7:0] t  [0:3];
	logic [7:0] a0, a1, a2, a3, all;

	// split key into bytes, byte 0 at the top
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			kb[i] = rk[amp_pkg::BLK_W-1-8*i -: 8];
		end
	end

	// key step: rotated, substituted last word plus round constant
	always_comb begin
		t[0] = amp_pkg::SBOX[kb[13]] ^ rc;
		t[1] = amp_pkg::SBOX[kb[14]];
		t[2] = amp_pkg::SBOX[kb[15]];
		t[3] = amp_pkg::SBOX[kb[12]];
		for (int w = 0; w < 4; w++) begin
			for (int r = 0; r < 4; r++) begin
				t[r] = t[r] ^ kb[4*w+r];
				rk_nxt[amp_pkg::BLK_W-1-8*(4*w+r) -: 8] = t[r];
			end
		end
	end

	// sub bytes and shift rows
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[4*c+r] = amp_pkg::SBOX[st[amp_pkg::BLK_W-1-8*(4*((c+r)%4)+r) -: 8]];
			end
		end
	end

	// mix columns unless final round, then add next round key
	always_comb begin
		a0 = '0; a1 = '0; a2 = '0; a3 = '0; all = '0;
		for (int c = 0; c < 4; c++) begin
			a0  = sb[4*c];
			a1  = sb[4*c+1];
			a2  = sb[4*c+2];
			a3  = sb[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			if (mix) begin
				ob[4*c]   = a0 ^ all ^ amp_pkg::gf_dbl(a0 ^ a1);
				ob[4*c+1] = a1 ^ all ^ amp_pkg::gf_dbl(a1 ^ a2);
				ob[4*c+2] = a2 ^ all ^ amp_pkg::gf_dbl(a2 ^ a3);
				ob[4*c+3] = a3 ^ all ^ amp_pkg::gf_dbl(a3 ^ a0);
			end else begin
				ob[4*c]   = a0;
				ob[4*c+1] = a1;
				ob[4*c+2] = a2;
				ob[4*c+3] = a3;
			end
		end
		for (int i = 0; i < 16; i++) begin
			st_nxt[amp_pkg::BLK_W-1-8*i -: 8] = ob[i] ^ rk_nxt[amp_pkg::BLK_W-1-8*i -: 8];
		end
	end

endmodule

// ===== rtl/aes128_mp_owf_prg.sv =====
// AES-128 Miyaguchi-Preneel one-way function and chained block generator.
// Request channel (req): func, key and message halves, n_blocks. func 0 gives
// one block E_key(msg) ^ key ^ msg; func 1 ignores the key and gives a run of
// n_blocks chained blocks (0 counts as 1, above MAX_BLOCKS clamps), the first
// keyed by a fixed IV and each later one keyed by the previous block.
// Response channel (rsp): block halves, block_index and last on the final one.
// Both channels move an item on a clock edge with valid and ready high.
// Timing: one round per cycle through a single shared round unit with the key
// schedule worked on the fly; each block runs its ten rounds in the run state,
// then the finish state moves it into the output register, and waits there
// while that register still holds a block the receiver has not taken.
// req.ready is high only while no run is in progress; a new request may be
// taken while the last block still waits in the output register.
// A stalled receiver holds the finished block in the output register; the
// next block is computed meanwhile and then waits until that register frees.
// Reset (arst_n low) drops any run and clears rsp.valid; nothing else needs
// clearing.
module aes128_mp_owf_prg #(
	parameter int MAX_BLOCKS = amp_pkg::MAX_BLOCKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	amp_req_if.sink   req,
	amp_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                    state_q;
	logic [amp_pkg::ROUND_W-1:0]   round_q;
	logic [amp_pkg::IDX_W-1:0]     idx_q;
	logic [amp_pkg::NBLK_W-1:0]    n_q;
	logic [7:0]                    rc_q;
	logic [amp_pkg::BLK_W-1:0]     st_q, rk_q, key_q, msg_q;
	logic                          out_valid_q;
	logic [amp_pkg::BLK_W-1:0]     out_blk_q;
	logic [amp_pkg::IDX_W-1:0]     out_idx_q;
	logic                          out_last_q;

	logic                          accept;
	logic                          load_out;
	logic                          last_w;
	logic [amp_pkg::BLK_W-1:0]     in_key, in_msg, blk_w;
	logic [amp_pkg::NBLK_W-1:0]    n_sat;
	logic [amp_pkg::BLK_W-1:0]     st_nxt, rk_nxt;

	amp_round u_round (
		.st     (st_q),
		.rk     (rk_q),
		.rc     (rc_q),
		.mix    (round_q != amp_pkg::LAST_ROUND),
		.st_nxt (st_nxt),
		.rk_nxt (rk_nxt)
	);

	// handshake and request decode
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_msg    = {req.msg_hi, req.msg_lo};
	assign in_key    = req.func ? amp_pkg::FIXED_IV : {req.key_hi, req.key_lo};

	// clamp run length; func 0 or a zero count gives one block
	always_comb begin
		if (!req.func || req.n_blocks == '0) begin
			n_sat = amp_pkg::NBLK_W'(1);
		end else if (req.n_blocks > amp_pkg::NBLK_W'(MAX_BLOCKS)) begin
			n_sat = amp_pkg::NBLK_W'(MAX_BLOCKS);
		end else begin
			n_sat = req.n_blocks;
		end
	end

	// finished block and output register handoff
	assign blk_w    = st_q ^ key_q ^ msg_q;
	assign last_w   = ({1'b0, idx_q} + amp_pkg::NBLK_W'(1)) == n_q;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (round_q == amp_pkg::LAST_ROUND) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) state_q <= last_w ? ST_IDLE : ST_RUN;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: load, advance one round, chain next block
	always_ff @(posedge clk) begin
		if (accept) begin
			msg_q   <= in_msg;
			key_q   <= in_key;
			rk_q    <= in_key;
			st_q    <= in_msg ^ in_key;
			rc_q    <= amp_pkg::RC_INIT;
			round_q <= amp_pkg::ROUND_W'(1);
			idx_q   <= '0;
			n_q     <= n_sat;
		end else if (state_q == ST_RUN) begin
			st_q    <= st_nxt;
			rk_q    <= rk_nxt;
			rc_q    <= amp_pkg::gf_dbl(rc_q);
			round_q <= round_q + amp_pkg::ROUND_W'(1);
		end else if (load_out && !last_w) begin
			key_q   <= blk_w;
			rk_q    <= blk_w;
			st_q    <= msg_q ^ blk_w;
			rc_q    <= amp_pkg::RC_INIT;
			round_q <= amp_pkg::ROUND_W'(1);
			idx_q   <= idx_q + amp_pkg::IDX_W'(1);
		end
		if (load_out) begin
			out_blk_q  <= blk_w;
			out_idx_q  <= idx_q;
			out_last_q <= last_w;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.block_hi    = out_blk_q[amp_pkg::BLK_W-1 -: amp_pkg::HALF_W];
	assign rsp.block_lo    = out_blk_q[amp_pkg::HALF_W-1:0];
	assign rsp.block_index = out_idx_q;
	assign rsp.last        = out_last_q;

	// a taken request starts round one
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (round_q == amp_pkg::ROUND_W'(1)))
		else $error("request did not start round one");

	// rounds stay within one to ten while running
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (round_q != '0) && (round_q <= amp_pkg::LAST_ROUND))
		else $error("round counter out of range");

	// the final block of a run returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_w) |=> (state_q == ST_IDLE) && out_valid_q && rsp.last)
		else $error("run did not end after final block");

	// block index stays below the run length while busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, idx_q} < n_q))
		else $error("block index beyond run length");

endmodule

// ===== verif/aes128_mp_owf_prg_tb.sv =====
module aes128_mp_owf_prg_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_OWF = 1'b0;
	localparam logic FUNC_PRG = 1'b1;

	localparam int DIR_N       = 15;
	localparam int RAND_N      = 420;
	localparam int RUN_MAX     = 64;
	localparam int BLK_CYC     = 12;
	localparam int REQ_GAP_MAX = 40;
	localparam int RSP_GAP_MAX = 40;
	localparam int DRAIN_CYC   = 40;
	localparam longint LIMIT   = longint'(DIR_N + RAND_N)
		* (RUN_MAX * (BLK_CYC + RSP_GAP_MAX + 1) + REQ_GAP_MAX + 20) * 4;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [5:0]  index;
		logic        last;
	} block_t;

	typedef struct {
		logic        func;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] msg_hi;
		logic [63:0] msg_lo;
		logic [6:0]  n_blocks;
		logic        known;
		logic [63:0] known_hi;
		logic [63:0] known_lo;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	amp_req_if req_ch();
	amp_rsp_if rsp_ch();

	aes128_mp_owf_prg uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	block_t pending_blocks [$];
	int     err_cnt = 0;

	// receiver stall state
	int rsp_hold  = 0;
	int calm_left = 200;
	bit rsp_calm  = 1'b0;

	// directed rows: published AES vectors folded into the MP output, field extremes,
	// run-length saturation at both ends, and a key that generator mode must ignore
	stim_row_t dir_tab [DIR_N] = '{
		'{FUNC_OWF, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h0011223344556677, 64'h8899aabbccddeeff, 7'd1,
			1'b1, 64'h69d4c0e82a2b6440, 64'h585d1730b06425aa},
		'{FUNC_PRG, 64'h0, 64'h0, 64'h3243f6a8885a308d, 64'h313198a2e0370734, 7'd1,
			1'b1, 64'h201867a3a228ebd0, 64'h46d708bdf092433a},
		'{FUNC_OWF, 64'h0, 64'h0, 64'h0, 64'h0, 7'd0, 1'b0, 64'h0, 64'h0},
		'{FUNC_OWF, '1, '1, '1, '1, 7'd127, 1'b0, 64'h0, 64'h0},
		'{FUNC_OWF, 64'h0, 64'h0, '1, '1, 7'd64, 1'b0, 64'h0, 64'h0},
		'{FUNC_OWF, '1, '1, 64'h0, 64'h0, 7'd65, 1'b0, 64'h0, 64'h0},
		'{FUNC_OWF, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a,
			64'h0123456789abcdef, 64'hfedcba9876543210, 7'd3, 1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, 64'h0, 64'h0, 64'h0, 64'h0, 7'd0, 1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, 64'h0, 64'h0, 64'h0, 64'h0, 7'd1, 1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, '1, '1, 64'h0011223344556677, 64'h8899aabbccddeeff, 7'd2,
			1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, 64'h0, 64'h0, '1, '1, 7'd64, 1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, 64'h0, 64'h0, 64'h8000000000000001, 64'h0000000000000001, 7'd65,
			1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, '1, '1, 64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978, 7'd127,
			1'b0, 64'h0, 64'h0},
		'{FUNC_PRG, 64'h1111111111111111, 64'h2222222222222222,
			64'h3243f6a8885a308d, 64'h313198a2e0370734, 7'd3, 1'b0, 64'h0, 64'h0},
		'{FUNC_OWF, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
			64'h3243f6a8885a308d, 64'h313198a2e0370734, 7'd0,
			1'b1, 64'h201867a3a228ebd0, 64'h46d708bdf092433a}
	};

	// multiply by x modulo the AES field polynomial
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? amp_pkg::GF_POLY : 8'h00);
	endfunction

	// AES-128 of msg under key, folded with key and msg
	function automatic logic [127:0] mp_compress(input logic [127:0] key,
		input logic [127:0] msg);
		logic [7:0] rk [16];
		logic [7:0] st [16];
		logic [7:0] o [16];
		logic [7:0] t [4];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] res;
		int i, c, r, rnd;
		for (i = 0; i < 16; i++) begin
			rk[i] = key[127 - 8 * i -: 8];
			st[i] = msg[127 - 8 * i -: 8] ^ rk[i];
		end
		rc = amp_pkg::RC_INIT;
		for (rnd = 1; rnd <= 10; rnd++) begin
			// substitute and shift rows
			for (c = 0; c < 4; c++)
				for (r = 0; r < 4; r++)
					o[4 * c + r] = amp_pkg::SBOX[st[4 * ((c + r) & 3) + r]];
			// mix columns on all but the final round
			if (rnd != 10) begin
				for (c = 0; c < 4; c++) begin
					a0 = o[4 * c];
					a1 = o[4 * c + 1];
					a2 = o[4 * c + 2];
					a3 = o[4 * c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					o[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
					o[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
					o[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
					o[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
				end
			end
			for (i = 0; i < 16; i++)
				st[i] = o[i];
			// advance the round key
			t[0] = amp_pkg::SBOX[rk[13]] ^ rc;
			t[1] = amp_pkg::SBOX[rk[14]];
			t[2] = amp_pkg::SBOX[rk[15]];
			t[3] = amp_pkg::SBOX[rk[12]];
			for (i = 0; i < 16; i++) begin
				rk[i] = rk[i] ^ t[i & 3];
				t[i & 3] = rk[i];
			end
			rc = xtime(rc);
			for (i = 0; i < 16; i++)
				st[i] = st[i] ^ rk[i];
		end
		for (i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = st[i] ^ key[127 - 8 * i -: 8] ^ msg[127 - 8 * i -: 8];
		return res;
	endfunction

	// queue the blocks one accepted item yields
	task automatic chain_blocks(input logic func, input logic [127:0] key,
		input logic [127:0] msg, input logic [6:0] n_blocks);
		block_t b;
		logic [127:0] chain_key;
		logic [127:0] blk;
		int n, k;
		if (func == FUNC_OWF) begin
			blk = mp_compress(key, msg);
			b.hi = blk[127:64];
			b.lo = blk[63:0];
			b.index = '0;
			b.last = 1'b1;
			pending_blocks.push_back(b);
		end else begin
			n = int'(n_blocks);
			if (n < 1)
				n = 1;
			if (n > RUN_MAX)
				n = RUN_MAX;
			chain_key = amp_pkg::FIXED_IV;
			for (k = 0; k < n; k++) begin
				blk = mp_compress(chain_key, msg);
				b.hi = blk[127:64];
				b.lo = blk[63:0];
				b.index = 6'(k);
				b.last = (k == n - 1);
				pending_blocks.push_back(b);
				chain_key = blk;
			end
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, REQ_GAP_MAX);
		return $urandom_range(1, 3);
	endfunction

	// half of a key or message, with the extremes over-weighted
	function automatic logic [63:0] rand_half();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// run length: mostly short, sometimes long, now and then out of range
	function automatic logic [6:0] rand_run();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return 7'($urandom_range(1, 4));
		if (p < 92)
			return 7'($urandom_range(5, 16));
		if (p < 97)
			return 7'($urandom_range(0, 127));
		return 7'd0;
	endfunction

	// present one item after a gap and hold it until taken
	task automatic drive_item(input logic func, input logic [63:0] kh, input logic [63:0] kl,
		input logic [63:0] mh, input logic [63:0] ml, input logic [6:0] nb, input int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.func     <= func;
		req_ch.key_hi   <= kh;
		req_ch.key_lo   <= kl;
		req_ch.msg_hi   <= mh;
		req_ch.msg_lo   <= ml;
		req_ch.n_blocks <= nb;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		while (pending_blocks.size() != 0)
			@(posedge clk);
	endtask

	always #4 clk = ~clk;

	// check each taken block against the oldest expectation, then pick ready
	always @(posedge clk) begin
		block_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_blocks.size() == 0) begin
				$error("block %h_%h index %0d with nothing expected",
					rsp_ch.block_hi, rsp_ch.block_lo, rsp_ch.block_index);
				err_cnt++;
			end else begin
				want = pending_blocks.pop_front();
				if (rsp_ch.block_hi !== want.hi) begin
					$error("block_hi expected %h got %h", want.hi, rsp_ch.block_hi);
					err_cnt++;
				end
				if (rsp_ch.block_lo !== want.lo) begin
					$error("block_lo expected %h got %h", want.lo, rsp_ch.block_lo);
					err_cnt++;
				end
				if (rsp_ch.block_index !== want.index) begin
					$error("block_index expected %0d got %0d", want.index, rsp_ch.block_index);
					err_cnt++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last expected %0d got %0d", want.last, rsp_ch.last);
					err_cnt++;
				end
			end
		end
		// alternate calm stretches with stalling ones
		if (calm_left == 0) begin
			rsp_calm = ~rsp_calm;
			calm_left = $urandom_range(50, 400);
		end else begin
			calm_left--;
		end
		if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= arst_n;
			if (!rsp_calm && $urandom_range(0, 3) == 0)
				rsp_hold = pick_gap();
		end
	end

	// end the run if it hangs
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("aes128_mp_owf_prg verification failed");
		$finish;
	end

	initial begin
		stim_row_t row;
		block_t b;
		logic f;
		logic [63:0] kh, kl, mh, ml;
		logic [6:0] nb;
		int gap;
		req_ch.valid    = 1'b0;
		req_ch.func     = FUNC_OWF;
		req_ch.key_hi   = '0;
		req_ch.key_lo   = '0;
		req_ch.msg_hi   = '0;
		req_ch.msg_lo   = '0;
		req_ch.n_blocks = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_N; i++) begin
			row = dir_tab[i];
			gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
			drive_item(row.func, row.key_hi, row.key_lo, row.msg_hi, row.msg_lo,
				row.n_blocks, gap);
			if (row.known) begin
				b.hi = row.known_hi;
				b.lo = row.known_lo;
				b.index = '0;
				b.last = 1'b1;
				pending_blocks.push_back(b);
			end else begin
				chain_blocks(row.func, {row.key_hi, row.key_lo}, {row.msg_hi, row.msg_lo},
					row.n_blocks);
			end
		end
		// hold off until the directed part has fully drained
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		// random items
		for (int i = 0; i < RAND_N; i++) begin
			if (i == RAND_N / 2) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			f  = ($urandom_range(0, 99) < 45) ? FUNC_OWF : FUNC_PRG;
			kh = rand_half();
			kl = rand_half();
			mh = rand_half();
			ml = rand_half();
			nb = rand_run();
			if ((i / 60) % 3 == 1)
				gap = 0;
			else
				gap = ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
			drive_item(f, kh, kl, mh, ml, nb, gap);
			chain_blocks(f, {kh, kl}, {mh, ml}, nb);
		end
		req_ch.valid <= 1'b0;

		// drain, then watch for stray blocks
		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (pending_blocks.size() != 0) begin
			$error("%0d blocks never arrived", pending_blocks.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("aes128_mp_owf_prg verification clean");
		else
			$display("aes128_mp_owf_prg verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/amp_pkg.sv
rtl/amp_req_if.sv
rtl/amp_rsp_if.sv
rtl/amp_round.sv
rtl/aes128_mp_owf_prg.sv
verif/aes128_mp_owf_prg_tb.sv
